@@ rtl/core/pic_pkg.sv @@
package pic_pkg;

  // Counter width of the tick counter and the captured values.
  localparam int COUNT_BITS = 16;

  // Field widths.
  localparam int PDIV_W = 17;
  localparam int WRAP_W = 16;
  localparam int PSC_W  = 16;
  localparam int OUT_W  = COUNT_BITS + 1;
  localparam int DUTY_W = 7;

  // Wrap compare is done at the wider of the counter and the limit.
  localparam int CMP_W = (COUNT_BITS > WRAP_W) ? COUNT_BITS : WRAP_W;

  // Duty divider: dividend is high_ticks * 100, one quotient bit per step.
  localparam int QBITS   = DUTY_W;
  localparam int QSTEP_W = $clog2(QBITS);
  localparam int DIVD_W  = OUT_W + QBITS;

  // Constants.
  localparam logic [DUTY_W-1:0] DUTY_FULL  = 7'd100;
  localparam logic [PDIV_W-1:0] PDIV_MAX   = 17'd65536;
  localparam logic [PDIV_W-1:0] PDIV_RESET = 17'd200;
  localparam logic [WRAP_W-1:0] WRAP_RESET = 16'd65535;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic {
    REG_PRESCALE = 1'b0,
    REG_WRAP     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PDIV_W-1:0] prescale_divide;
    logic [WRAP_W-1:0] count_wrap_limit;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;      // an input beat is taken this cycle
    logic load_div;  // set up the duty division
    logic div_step;  // one quotient bit
    logic load_out;  // move the finished result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic falling;   // the pin sample at the input is a falling edge
    logic div_last;  // the divider is on its last quotient bit
  } dp_sts_t;

endpackage

@@ rtl/core/pic_if.sv @@
// Input channel: one pin sample per beat.
interface pic_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

// Result channel: one period and duty measurement per beat.
interface pic_out_if;
  logic                      valid;
  logic                      ready;
  logic [pic_pkg::OUT_W-1:0]  period_ticks;
  logic [pic_pkg::OUT_W-1:0]  high_ticks;
  logic [pic_pkg::DUTY_W-1:0] duty_percent;

  modport source (output valid, output period_ticks, output high_ticks,
                  output duty_percent, input ready);
  modport sink   (input valid, input period_ticks, input high_ticks,
                  input duty_percent, output ready);
endinterface

@@ rtl/core/pic_regs.sv @@
module pic_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pic_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pic_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready,
  output pic_pkg::cfg_t                  cfg
);
  import pic_pkg::*;

  logic [PDIV_W-1:0] prescale_divide_r;
  logic [WRAP_W-1:0] count_wrap_limit_r;
  logic              wr_en;
  reg_idx_t          idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign idx        = reg_idx_t'(cfg_paddr[2]);

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_divide_r  <= PDIV_RESET;
      count_wrap_limit_r <= WRAP_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_PRESCALE: prescale_divide_r  <= cfg_pwdata[PDIV_W-1:0];
        REG_WRAP:     count_wrap_limit_r <= cfg_pwdata[WRAP_W-1:0];
        default:      ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (idx)
      REG_PRESCALE: cfg_prdata = CFG_DATA_W'(prescale_divide_r);
      REG_WRAP:     cfg_prdata = CFG_DATA_W'(count_wrap_limit_r);
      default:      cfg_prdata = '0;
    endcase
  end

  assign cfg.prescale_divide  = prescale_divide_r;
  assign cfg.count_wrap_limit = count_wrap_limit_r;

endmodule

@@ rtl/core/pic_dp.sv @@
module pic_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pic_pkg::cfg_t               cfg,
  input  pic_pkg::dp_cmd_t            cmd,
  output pic_pkg::dp_sts_t            sts,
  input  logic                        pin_level,
  output logic [pic_pkg::OUT_W-1:0]   period_ticks,
  output logic [pic_pkg::OUT_W-1:0]   high_ticks,
  output logic [pic_pkg::DUTY_W-1:0]  duty_percent
);
  import pic_pkg::*;

  // Measurement state.
  logic [PSC_W-1:0]      psc_r, psc_nxt;
  logic [COUNT_BITS-1:0] tick_r, tick_nxt;
  logic                  prev_r;
  logic [COUNT_BITS-1:0] cap_per_r;
  logic [COUNT_BITS-1:0] cap_high_r;

  // Divider state.
  logic [OUT_W-1:0]   per_r;
  logic [OUT_W-1:0]   hi_r;
  logic [DIVD_W-1:0]  rem_r;
  logic [QBITS-1:0]   quo_r;
  logic [QSTEP_W-1:0] qstep_r;
  logic               sat_r;

  // Output register.
  logic [OUT_W-1:0]  out_per_r;
  logic [OUT_W-1:0]  out_hi_r;
  logic [DUTY_W-1:0] out_duty_r;

  logic [PDIV_W-1:0] eff_div;
  logic [PSC_W:0]    psc_plus;
  logic              tick_done;
  logic              wrap_hit;
  logic              rising;
  logic              falling;
  logic [OUT_W-1:0]  per_calc;
  logic [OUT_W-1:0]  hi_calc;
  logic [DIVD_W-1:0] dsor_shift;

  // Edge detect on the incoming sample.
  assign rising  = pin_level && !prev_r;
  assign falling = !pin_level && prev_r;

  // Prescaler and tick counter advance.
  always_comb begin
    if (cfg.prescale_divide == '0) begin
      eff_div = PDIV_W'(1);
    end else if (cfg.prescale_divide > PDIV_MAX) begin
      eff_div = PDIV_MAX;
    end else begin
      eff_div = cfg.prescale_divide;
    end
    psc_plus  = {1'b0, psc_r} + (PSC_W+1)'(1);
    tick_done = (PDIV_W'(psc_plus) >= eff_div);
    wrap_hit  = (CMP_W'(tick_r) == CMP_W'(cfg.count_wrap_limit));
    if (tick_done) begin
      psc_nxt  = '0;
      tick_nxt = wrap_hit ? '0 : tick_r + COUNT_BITS'(1);
    end else begin
      psc_nxt  = psc_plus[PSC_W-1:0];
      tick_nxt = tick_r;
    end
  end

  // Counters and captures, one update per input beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psc_r      <= '0;
      tick_r     <= '0;
      prev_r     <= 1'b0;
      cap_per_r  <= '0;
      cap_high_r <= '0;
    end else if (cmd.step) begin
      prev_r <= pin_level;
      if (rising) begin
        cap_per_r <= tick_r;
        tick_r    <= '0;
        psc_r     <= '0;
      end else begin
        if (falling) begin
          cap_high_r <= tick_r;
        end
        psc_r  <= psc_nxt;
        tick_r <= tick_nxt;
      end
    end
  end

  // Restoring divider for the duty quotient, one bit per cycle.
  assign per_calc   = OUT_W'(cap_per_r) + OUT_W'(1);
  assign hi_calc    = OUT_W'(cap_high_r) + OUT_W'(1);
  assign dsor_shift = DIVD_W'(per_r) << qstep_r;

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      per_r   <= per_calc;
      hi_r    <= hi_calc;
      sat_r   <= (hi_calc >= per_calc);
      rem_r   <= DIVD_W'(hi_calc) * DIVD_W'(DUTY_FULL);
      quo_r   <= '0;
      qstep_r <= QSTEP_W'(QBITS - 1);
    end else if (cmd.div_step) begin
      if (rem_r >= dsor_shift) begin
        rem_r          <= rem_r - dsor_shift;
        quo_r[qstep_r] <= 1'b1;
      end
      qstep_r <= qstep_r - QSTEP_W'(1);
    end
  end

  // Result register toward the output channel.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_per_r  <= per_r;
      out_hi_r   <= hi_r;
      out_duty_r <= sat_r ? DUTY_FULL : DUTY_W'(quo_r);
    end
  end

  assign sts.falling  = falling;
  assign sts.div_last = (qstep_r == '0);

  assign period_ticks = out_per_r;
  assign high_ticks   = out_hi_r;
  assign duty_percent = out_duty_r;

endmodule

@@ rtl/core/pic_ctrl.sv @@
module pic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pic_pkg::dp_sts_t  sts,
  output pic_pkg::dp_cmd_t  cmd
);
  import pic_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_HOLD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;

  // The output register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready     = (state_r == ST_IDLE);
  assign cmd.step     = in_valid && in_ready;
  assign cmd.load_div = (state_r == ST_LOAD);
  assign cmd.div_step = (state_r == ST_DIV);
  assign cmd.load_out = (state_r == ST_HOLD) && slot_free;
  assign out_valid    = out_valid_r;

  // Sequencer and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.step && sts.falling) begin
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (sts.div_last) begin
            state_r <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // A falling-edge beat always starts the division.
  a_fall_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && sts.falling |=> state_r == ST_LOAD)
    else $error("falling edge beat did not start the divider");

  // No input is taken while a measurement is being finished.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready)
    else $error("input ready while the divider is busy");

  // A result is never written over one that still waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten before it was taken");

  // Loading a result makes it visible in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r && state_r == ST_IDLE)
    else $error("loaded result not presented");

endmodule

@@ rtl/core/pwm_input_period_duty_capture.sv @@
// PWM input capture: one pin sample per input beat, one result per falling edge.
// A sample that is not a falling edge leaves the sequencer idle; the next beat follows at once.
// A falling edge passes through a setup state, the divider state and an output load
// before its result appears, and holds the input off until then, longer while an
// earlier result still waits at the output. Synchronous active-low reset clears
// counters and captures and returns the registers to 200 and 65535.
module pwm_input_period_duty_capture (
  input  logic                           clk,
  input  logic                           rst_n,
  pic_in_if.sink                         in_ch,
  pic_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pic_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pic_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pic_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import pic_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // Configuration registers.
  pic_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Sequencer.
  pic_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Counters, captures and duty divider.
  pic_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .cmd          (cmd),
    .sts          (sts),
    .pin_level    (in_ch.pin_level),
    .period_ticks (out_ch.period_ticks),
    .high_ticks   (out_ch.high_ticks),
    .duty_percent (out_ch.duty_percent)
  );

endmodule
